@@ rtl/core/drive_mode_sequencer_with_debounce_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the drive mode sequencer
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef DRIVE_MODE_SEQUENCER_WITH_DEBOUNCE_ASSERT_SVH
`define DRIVE_MODE_SEQUENCER_WITH_DEBOUNCE_ASSERT_SVH

// explicit clock and reset
`define DMSD_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dmsd assertion failed");

// default clock and reset names of this block
`define DMSD_ASSERT(lbl, prop) `DMSD_ASSERT_CLK(lbl, clock, reset, prop)

`endif

@@ rtl/core/dmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// dmsd_pkg
// Shared widths, register map and debounce cell type for the drive mode
// sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmsd_pkg;

   localparam int CNT_W    = 8;
   localparam int PUMP_W   = 3;
   localparam int LEVEL_W  = 8;
   localparam int ERRC_W   = 8;
   localparam int MODE_W   = 3;
   localparam int VISIT_W  = 5;
   localparam int SUM_W    = 32;
   localparam int SAMPLE_W = 25;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [VISIT_W-1:0] ERROR_HALT_COUNT = 5'd20;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_BOAT_TICKS   = 2'd0;
   localparam logic [1:0] REG_MOTOR_TICKS  = 2'd1;
   localparam logic [1:0] REG_DEADMAN_TICKS = 2'd2;
   localparam logic [1:0] REG_SAMPLE_LIMIT = 2'd3;

   localparam logic [CNT_W-1:0]    RST_DEBOUNCE_TICKS = 8'd10;
   localparam logic [SAMPLE_W-1:0] RST_SAMPLE_LIMIT   = 25'd16843009;

   // one debounced switch: on/off counters and the flag
   typedef struct packed {
      logic [CNT_W-1:0] cnt_on;
      logic [CNT_W-1:0] cnt_off;
      logic             flag;
   } dbnc_type;

endpackage

`default_nettype wire

@@ rtl/core/dmsd_if.sv @@
// ----------------------------------------------------------------------------
// dmsd_req_if / dmsd_rsp_if
// Valid/ready channels for control ticks and sequencer results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dmsd_req_if
   import dmsd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              boat_switch_n;
   logic              motor_switch_n;
   logic              dead_man_n;
   logic              mcc_switch_n;
   logic [PUMP_W-1:0]  pump_switches_n;
   logic [LEVEL_W-1:0] pwm_pot_level;
   logic [LEVEL_W-1:0] ramp_pot_level;
   logic [LEVEL_W-1:0] power_pot_level;
   logic [ERRC_W-1:0]  error_code;

   modport source (
      output valid, boat_switch_n, motor_switch_n, dead_man_n, mcc_switch_n,
             pump_switches_n, pwm_pot_level, ramp_pot_level, power_pot_level,
             error_code,
      input  ready
   );
   modport sink (
      input  valid, boat_switch_n, motor_switch_n, dead_man_n, mcc_switch_n,
             pump_switches_n, pwm_pot_level, ramp_pot_level, power_pot_level,
             error_code,
      output ready
   );
endinterface

interface dmsd_rsp_if
   import dmsd_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic                boat_on;
   logic                motor_active;
   logic                dead_man_on;
   logic                mcc_on;
   logic [PUMP_W-1:0]   pumps_on;
   logic [VISIT_W-1:0]  error_total;
   logic [SUM_W-1:0]    pwm_sum;
   logic [SUM_W-1:0]    ramp_sum;
   logic [SUM_W-1:0]    power_sum;
   logic [SAMPLE_W-1:0] sample_count;

   modport source (
      output valid, mode, boat_on, motor_active, dead_man_on, mcc_on, pumps_on,
             error_total, pwm_sum, ramp_sum, power_sum, sample_count,
      input  ready
   );
   modport sink (
      input  valid, mode, boat_on, motor_active, dead_man_on, mcc_on, pumps_on,
             error_total, pwm_sum, ramp_sum, power_sum, sample_count,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/core/dmsd_debounce.sv @@
// ----------------------------------------------------------------------------
// dmsd_debounce
// Next-state logic of one switch debouncer with wrapping on/off counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmsd_debounce
   import dmsd_pkg::*;
(
   input  wire logic             pressed,
   input  wire logic [CNT_W-1:0] ticks,
   input  wire dbnc_type         cur,
   output dbnc_type              nxt
);

   always_comb begin
      nxt = cur;
      if (pressed) begin
         nxt.cnt_on = cur.cnt_on + {{(CNT_W-1){1'b0}}, 1'b1};
         if (nxt.cnt_on >= ticks) begin
            nxt.cnt_off = '0;
            nxt.flag    = 1'b1;
         end
      end else begin
         nxt.cnt_off = cur.cnt_off + {{(CNT_W-1){1'b0}}, 1'b1};
         if (nxt.cnt_off >= ticks) begin
            nxt.cnt_on = '0;
            nxt.flag   = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/drive_mode_sequencer_with_debounce.sv @@
// An accepted item passes through the input register and then the
// state/result register, which drives rsp. Throughput: one item per clock
// while rsp does not stall; the input register and the state/result
// register form a two-stage pipe, and the state advances once per item.
// The result register holds while rsp stalls; the input stage still fills.
// Reset (synchronous, active high) clears mode to init, all counters, flags,
// sums and pipe valids, and loads the register defaults.
// ----------------------------------------------------------------------------
// drive_mode_sequencer_with_debounce
// Mode sequencer for a drive controller: debounces switches, tracks error
// visits and accumulates potentiometer levels while running.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "drive_mode_sequencer_with_debounce_assert.svh"

module drive_mode_sequencer_with_debounce
   import dmsd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   dmsd_req_if.sink               req,
   dmsd_rsp_if.source             rsp,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT = 3'd0,
      MODE_IDLE = 3'd1,
      MODE_RUN  = 3'd2,
      MODE_ERR  = 3'd3,
      MODE_HALT = 3'd4
   } mode_type;

   // configuration
   logic [CNT_W-1:0]    boat_ticks_ff, motor_ticks_ff, dms_ticks_ff;
   logic [SAMPLE_W-1:0] limit_ff;
   logic                csr_wr;

   // input stage
   logic               in_v_ff;
   logic               boat_p_ff, motor_p_ff, dms_p_ff, mcc_p_ff;
   logic [PUMP_W-1:0]  pumps_n_ff;
   logic [LEVEL_W-1:0] pwm_lvl_ff, ramp_lvl_ff, power_lvl_ff;
   logic               err_ff;

   // state, which is also the result
   logic                out_v_ff, out_v_in;
   mode_type            mode_ff, mode_in, mode_eff;
   dbnc_type            boat_ff, boat_in, boat_nx;
   dbnc_type            motor_ff, motor_in, motor_nx;
   dbnc_type            dms_ff, dms_in, dms_nx;
   logic                mcc_ff, mcc_in;
   logic [PUMP_W-1:0]   pumps_ff, pumps_in;
   logic [VISIT_W-1:0]  visits_ff, visits_in;
   logic [SUM_W-1:0]    pwm_sum_ff, pwm_sum_in;
   logic [SUM_W-1:0]    ramp_sum_ff, ramp_sum_in;
   logic [SUM_W-1:0]    power_sum_ff, power_sum_in;
   logic [SAMPLE_W-1:0] count_ff, count_in;

   logic advance;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      unique case (paddr[3:2])
         REG_BOAT_TICKS:    prdata = {{(CSR_DW-CNT_W){1'b0}}, boat_ticks_ff};
         REG_MOTOR_TICKS:   prdata = {{(CSR_DW-CNT_W){1'b0}}, motor_ticks_ff};
         REG_DEADMAN_TICKS: prdata = {{(CSR_DW-CNT_W){1'b0}}, dms_ticks_ff};
         REG_SAMPLE_LIMIT:  prdata = {{(CSR_DW-SAMPLE_W){1'b0}}, limit_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boat_ticks_ff  <= RST_DEBOUNCE_TICKS;
         motor_ticks_ff <= RST_DEBOUNCE_TICKS;
         dms_ticks_ff   <= RST_DEBOUNCE_TICKS;
         limit_ff       <= RST_SAMPLE_LIMIT;
      end else if (csr_wr) begin
         unique case (paddr[3:2])
            REG_BOAT_TICKS:    boat_ticks_ff  <= pwdata[CNT_W-1:0];
            REG_MOTOR_TICKS:   motor_ticks_ff <= pwdata[CNT_W-1:0];
            REG_DEADMAN_TICKS: dms_ticks_ff   <= pwdata[CNT_W-1:0];
            REG_SAMPLE_LIMIT:  limit_ff       <= pwdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipe control ----------------
   assign advance   = in_v_ff && (!out_v_ff || rsp.ready);
   assign req.ready = !in_v_ff || advance;
   assign out_v_in  = advance ? 1'b1 : (out_v_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req.ready) begin
         in_v_ff <= req.valid;
      end
   end

   // switch pins are stored as active-high "pressed"; the pump pins stay active low
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         boat_p_ff    <= ~req.boat_switch_n;
         motor_p_ff   <= ~req.motor_switch_n;
         dms_p_ff     <= ~req.dead_man_n;
         mcc_p_ff     <= ~req.mcc_switch_n;
         pumps_n_ff   <= req.pump_switches_n;
         pwm_lvl_ff   <= req.pwm_pot_level;
         ramp_lvl_ff  <= req.ramp_pot_level;
         power_lvl_ff <= req.power_pot_level;
         err_ff       <= (req.error_code != '0);
      end
   end

   // ---------------- debouncers ----------------
   dmsd_debounce u_boat (
      .pressed (boat_p_ff),
      .ticks   (boat_ticks_ff),
      .cur     (boat_ff),
      .nxt     (boat_nx)
   );

   dmsd_debounce u_motor (
      .pressed (motor_p_ff),
      .ticks   (motor_ticks_ff),
      .cur     (motor_ff),
      .nxt     (motor_nx)
   );

   dmsd_debounce u_dms (
      .pressed (dms_p_ff),
      .ticks   (dms_ticks_ff),
      .cur     (dms_ff),
      .nxt     (dms_nx)
   );

   // ---------------- mode machine ----------------
   always_comb begin
      mode_in      = mode_ff;
      boat_in      = boat_ff;
      motor_in     = motor_ff;
      dms_in       = dms_ff;
      mcc_in       = mcc_ff;
      pumps_in     = pumps_ff;
      visits_in    = visits_ff;
      pwm_sum_in   = pwm_sum_ff;
      ramp_sum_in  = ramp_sum_ff;
      power_sum_in = power_sum_ff;
      count_in     = count_ff;

      // an error code preempts every mode but halted
      mode_eff = (mode_ff < MODE_HALT && err_ff) ? MODE_ERR : mode_ff;

      unique case (mode_eff)
         MODE_INIT: begin
            mode_in = MODE_IDLE;
         end
         MODE_IDLE: begin
            motor_in.flag = 1'b0;
            dms_in.flag   = 1'b0;
            mcc_in        = 1'b0;
            boat_in       = boat_nx;
            pumps_in      = ~pumps_n_ff;
            if (boat_nx.flag) begin
               mode_in = MODE_RUN;
            end
         end
         MODE_RUN: begin
            boat_in  = boat_nx;
            motor_in = motor_nx;
            dms_in   = dms_nx;
            mcc_in   = mcc_p_ff;
            pumps_in = ~pumps_n_ff;
            if (count_ff <= limit_ff) begin
               pwm_sum_in   = pwm_sum_ff + {{(SUM_W-LEVEL_W){1'b0}}, pwm_lvl_ff};
               ramp_sum_in  = ramp_sum_ff + {{(SUM_W-LEVEL_W){1'b0}}, ramp_lvl_ff};
               power_sum_in = power_sum_ff + {{(SUM_W-LEVEL_W){1'b0}}, power_lvl_ff};
               count_in     = count_ff + {{(SAMPLE_W-1){1'b0}}, 1'b1};
            end
            if (!boat_nx.flag) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_ERR: begin
            visits_in = visits_ff + {{(VISIT_W-1){1'b0}}, 1'b1};
            mode_in   = (visits_in >= ERROR_HALT_COUNT) ? MODE_HALT : MODE_INIT;
         end
         default: ; // halted: terminal
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff     <= 1'b0;
         mode_ff      <= MODE_INIT;
         boat_ff      <= '0;
         motor_ff     <= '0;
         dms_ff       <= '0;
         mcc_ff       <= 1'b0;
         pumps_ff     <= '0;
         visits_ff    <= '0;
         pwm_sum_ff   <= '0;
         ramp_sum_ff  <= '0;
         power_sum_ff <= '0;
         count_ff     <= '0;
      end else begin
         out_v_ff <= out_v_in;
         if (advance) begin
            mode_ff      <= mode_in;
            boat_ff      <= boat_in;
            motor_ff     <= motor_in;
            dms_ff       <= dms_in;
            mcc_ff       <= mcc_in;
            pumps_ff     <= pumps_in;
            visits_ff    <= visits_in;
            pwm_sum_ff   <= pwm_sum_in;
            ramp_sum_ff  <= ramp_sum_in;
            power_sum_ff <= power_sum_in;
            count_ff     <= count_in;
         end
      end
   end

   // ---------------- result ----------------
   assign rsp.valid        = out_v_ff;
   assign rsp.mode         = mode_ff;
   assign rsp.boat_on      = boat_ff.flag;
   assign rsp.motor_active = motor_ff.flag;
   assign rsp.dead_man_on  = dms_ff.flag;
   assign rsp.mcc_on       = mcc_ff;
   assign rsp.pumps_on     = pumps_ff;
   assign rsp.error_total  = visits_ff;
   assign rsp.pwm_sum      = pwm_sum_ff;
   assign rsp.ramp_sum     = ramp_sum_ff;
   assign rsp.power_sum    = power_sum_ff;
   assign rsp.sample_count = count_ff;

   // ---------------- assertions ----------------
   `DMSD_ASSERT(a_halt_sticky, (mode_ff == MODE_HALT) |=> (mode_ff == MODE_HALT))
   `DMSD_ASSERT(a_halt_at_limit,
      ((mode_ff != MODE_HALT) ##1 (mode_ff == MODE_HALT)) |-> (visits_ff == ERROR_HALT_COUNT))
   `DMSD_ASSERT(a_state_holds, (!advance) |=> $stable(pwm_sum_ff) && $stable(count_ff))
   `DMSD_ASSERT(a_item_kept, (in_v_ff && !advance) |=> in_v_ff)

endmodule

`default_nettype wire

@@ tb/sv/drive_mode_sequencer_with_debounce_test.sv @@
// ----------------------------------------------------------------------------
// drive_mode_sequencer_with_debounce_test
// Self-checking bench for the drive mode sequencer. Control ticks go in over
// the req channel under random bursts and gaps. A local mode/debounce/sum
// predictor queues the expected status of every accepted tick, and each
// status taken from the rsp channel is compared field by field. Debounce
// lengths and the sample limit change between phases over the APB port.
// The run ends by driving the block into the halted mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_mode_sequencer_with_debounce_test;
   import dmsd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT = 3'd0,
      MODE_IDLE = 3'd1,
      MODE_RUN  = 3'd2,
      MODE_ERR  = 3'd3,
      MODE_HALT = 3'd4
   } drive_mode_type;

   typedef enum int {
      SW_BOAT    = 0,
      SW_MOTOR   = 1,
      SW_DEADMAN = 2
   } switch_type;

   typedef struct {
      logic               boat_n;
      logic               motor_n;
      logic               dead_man_n;
      logic               mcc_n;
      logic [PUMP_W-1:0]  pumps_n;
      logic [LEVEL_W-1:0] pwm;
      logic [LEVEL_W-1:0] ramp;
      logic [LEVEL_W-1:0] power;
      logic [ERRC_W-1:0]  error_code;
   } tick_type;

   typedef struct {
      logic [MODE_W-1:0]   mode;
      logic                boat_on;
      logic                motor_active;
      logic                dead_man_on;
      logic                mcc_on;
      logic [PUMP_W-1:0]   pumps_on;
      logic [VISIT_W-1:0]  error_total;
      logic [SUM_W-1:0]    pwm_sum;
      logic [SUM_W-1:0]    ramp_sum;
      logic [SUM_W-1:0]    power_sum;
      logic [SAMPLE_W-1:0] sample_count;
   } tick_status_type;

   logic clock;
   logic reset;

   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   dmsd_req_if req_ch();
   dmsd_rsp_if rsp_ch();

   drive_mode_sequencer_with_debounce dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   drive_mode_type      seq_mode;
   dbnc_type            sw_state [3];
   logic [CNT_W-1:0]    sw_ticks [3];
   logic                mcc_flag;
   logic [PUMP_W-1:0]   pump_flags;
   logic [SUM_W-1:0]    level_sum [3];
   logic [SAMPLE_W-1:0] samples_taken;
   logic [SAMPLE_W-1:0] sample_limit;
   logic [VISIT_W-1:0]  error_visits;

   tick_status_type expected_status [$];
   tick_status_type want_status;
   int              mismatch_count;
   int              cycle_count;

   // stimulus shaping
   logic        held_pin [3];
   int          burst_left;
   int          gap_max;
   logic [15:0] stall_pattern;
   logic [3:0]  stall_phase;
   int          rsp_hold_cycles;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic reset_model();
      seq_mode      = MODE_INIT;
      mcc_flag      = 1'b0;
      pump_flags    = '0;
      samples_taken = '0;
      sample_limit  = RST_SAMPLE_LIMIT;
      error_visits  = '0;
      for (int s = 0; s < 3; s++) begin
         sw_state[s]  = '0;
         sw_ticks[s]  = RST_DEBOUNCE_TICKS;
         level_sum[s] = '0;
         held_pin[s]  = 1'b1;
      end
   endtask

   task automatic apply_register(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
         REG_BOAT_TICKS:    sw_ticks[SW_BOAT]    = value[CNT_W-1:0];
         REG_MOTOR_TICKS:   sw_ticks[SW_MOTOR]   = value[CNT_W-1:0];
         REG_DEADMAN_TICKS: sw_ticks[SW_DEADMAN] = value[CNT_W-1:0];
         REG_SAMPLE_LIMIT:  sample_limit         = value[SAMPLE_W-1:0];
         default: ;
      endcase
   endtask

   // counter of the present level keeps counting (and wraps); only the
   // opposite one is cleared when the threshold is met
   function automatic dbnc_type debounce_next(dbnc_type s, logic pressed,
                                              logic [CNT_W-1:0] ticks);
      dbnc_type n;
      n = s;
      if (pressed) begin
         n.cnt_on = s.cnt_on + 1'b1;
         if (n.cnt_on >= ticks) begin
            n.cnt_off = '0;
            n.flag    = 1'b1;
         end
      end else begin
         n.cnt_off = s.cnt_off + 1'b1;
         if (n.cnt_off >= ticks) begin
            n.cnt_on = '0;
            n.flag   = 1'b0;
         end
      end
      return n;
   endfunction

   function automatic tick_status_type sequence_tick(tick_type t);
      tick_status_type r;
      if (seq_mode < MODE_HALT && t.error_code != '0)
         seq_mode = MODE_ERR;
      case (seq_mode)
         MODE_INIT: seq_mode = MODE_IDLE;
         MODE_IDLE: begin
            sw_state[SW_MOTOR].flag   = 1'b0;
            sw_state[SW_DEADMAN].flag = 1'b0;
            mcc_flag                  = 1'b0;
            sw_state[SW_BOAT] = debounce_next(sw_state[SW_BOAT], !t.boat_n,
                                              sw_ticks[SW_BOAT]);
            pump_flags = ~t.pumps_n;
            if (sw_state[SW_BOAT].flag)
               seq_mode = MODE_RUN;
         end
         MODE_RUN: begin
            sw_state[SW_BOAT] = debounce_next(sw_state[SW_BOAT], !t.boat_n,
                                              sw_ticks[SW_BOAT]);
            sw_state[SW_MOTOR] = debounce_next(sw_state[SW_MOTOR], !t.motor_n,
                                               sw_ticks[SW_MOTOR]);
            sw_state[SW_DEADMAN] = debounce_next(sw_state[SW_DEADMAN], !t.dead_man_n,
                                                 sw_ticks[SW_DEADMAN]);
            mcc_flag   = !t.mcc_n;
            pump_flags = ~t.pumps_n;
            if (samples_taken <= sample_limit) begin
               level_sum[0]  = level_sum[0] + t.pwm;
               level_sum[1]  = level_sum[1] + t.ramp;
               level_sum[2]  = level_sum[2] + t.power;
               samples_taken = samples_taken + 1'b1;
            end
            if (!sw_state[SW_BOAT].flag)
               seq_mode = MODE_IDLE;
         end
         MODE_ERR: begin
            error_visits = error_visits + 1'b1;
            if (error_visits >= ERROR_HALT_COUNT)
               seq_mode = MODE_HALT;
            else
               seq_mode = MODE_INIT;
         end
         default: ;  // halted: nothing moves
      endcase
      r.mode         = seq_mode;
      r.boat_on      = sw_state[SW_BOAT].flag;
      r.motor_active = sw_state[SW_MOTOR].flag;
      r.dead_man_on  = sw_state[SW_DEADMAN].flag;
      r.mcc_on       = mcc_flag;
      r.pumps_on     = pump_flags;
      r.error_total  = error_visits;
      r.pwm_sum      = level_sum[0];
      r.ramp_sum     = level_sum[1];
      r.power_sum    = level_sum[2];
      r.sample_count = samples_taken;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want_v,
                                       logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // all tasks below are entered and left just after a falling edge
   task automatic send_tick(input tick_type t);
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         if (gap_max > 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(gap_max)) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.boat_switch_n   = t.boat_n;
      req_ch.motor_switch_n  = t.motor_n;
      req_ch.dead_man_n      = t.dead_man_n;
      req_ch.mcc_switch_n    = t.mcc_n;
      req_ch.pump_switches_n = t.pumps_n;
      req_ch.pwm_pot_level   = t.pwm;
      req_ch.ramp_pot_level  = t.ramp;
      req_ch.power_pot_level = t.power;
      req_ch.error_code      = t.error_code;
      req_ch.valid           = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_status.push_back(sequence_tick(t));
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_ch.valid = 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
   endtask

   // write, then read back
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] rd;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      apply_register(idx, value);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rd = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      check_field("csr readback", value, rd);
   endtask

   task automatic configure(input logic [CNT_W-1:0] boat, input logic [CNT_W-1:0] motor,
                            input logic [CNT_W-1:0] dead_man,
                            input logic [SAMPLE_W-1:0] limit);
      wait_for_results();
      csr_write(REG_BOAT_TICKS, 32'(boat));
      csr_write(REG_MOTOR_TICKS, 32'(motor));
      csr_write(REG_DEADMAN_TICKS, 32'(dead_man));
      csr_write(REG_SAMPLE_LIMIT, 32'(limit));
   endtask

   task automatic pick_idling();
      if ($urandom_range(3) == 0) begin
         gap_max       = 0;
         stall_pattern = '1;
      end else begin
         gap_max       = $urandom_range(8, 1);
         stall_pattern = 16'($urandom | $urandom) | 16'h0101;
      end
   endtask

   function automatic tick_type quiet_tick();
      tick_type t;
      t.boat_n     = 1'b1;
      t.motor_n    = 1'b1;
      t.dead_man_n = 1'b1;
      t.mcc_n      = 1'b1;
      t.pumps_n    = '1;
      t.pwm        = '0;
      t.ramp       = '0;
      t.power      = '0;
      t.error_code = '0;
      return t;
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_level();
      if ($urandom_range(7) == 0)
         return $urandom_range(1) ? 8'hFF : 8'h00;
      return LEVEL_W'($urandom_range(255));
   endfunction

   // rates in permille; switches hold their level between flips so steady
   // stretches long enough to pass the debounce come up naturally
   task automatic random_ticks(input int count, input int boat_flip,
                               input int switch_flip, input int error_rate);
      tick_type t;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(999) < boat_flip)
            held_pin[SW_BOAT] = ~held_pin[SW_BOAT];
         if ($urandom_range(999) < switch_flip)
            held_pin[SW_MOTOR] = ~held_pin[SW_MOTOR];
         if ($urandom_range(999) < switch_flip)
            held_pin[SW_DEADMAN] = ~held_pin[SW_DEADMAN];
         t.boat_n     = held_pin[SW_BOAT];
         t.motor_n    = held_pin[SW_MOTOR];
         t.dead_man_n = held_pin[SW_DEADMAN];
         t.mcc_n      = 1'($urandom_range(1));
         t.pumps_n    = PUMP_W'($urandom_range(7));
         t.pwm        = pick_level();
         t.ramp       = pick_level();
         t.power      = pick_level();
         t.error_code = '0;
         // keep error visits well short of the halt until the last test
         if (error_visits < 5'd17 && $urandom_range(999) < error_rate)
            t.error_code = ERRC_W'($urandom_range(255, 1));
         send_tick(t);
      end
   endtask

   // ------------------------------------------------------------------ tests

   task automatic test_directed_ticks();
      tick_type t;
      pick_idling();
      send_tick(quiet_tick());
      // boat held through the default debounce: idle -> running on the last
      for (int i = 0; i < 10; i++) begin
         t         = quiet_tick();
         t.boat_n  = 1'b0;
         t.pumps_n = i[2:0];
         t.pwm     = 8'hFF;
         send_tick(t);
      end
      t            = quiet_tick();
      t.boat_n     = 1'b0;
      t.motor_n    = 1'b0;
      t.dead_man_n = 1'b0;
      t.mcc_n      = 1'b0;
      t.pumps_n    = 3'b000;
      t.pwm        = 8'hFF;
      t.ramp       = 8'hFF;
      t.power      = 8'hFF;
      repeat (2) send_tick(t);
      t.mcc_n   = 1'b1;
      t.pumps_n = 3'b101;
      t.pwm     = 8'h00;
      t.ramp    = 8'h00;
      t.power   = 8'h00;
      send_tick(t);
      t.pwm   = 8'hFF;
      t.power = 8'h80;
      send_tick(t);
      t.error_code = 8'hFF;
      send_tick(t);
      t.error_code = 8'h01;
      send_tick(t);
      // boat flag survives the error, so the block goes back to running while the boat is released
      repeat (6) send_tick(quiet_tick());
   endtask

   task automatic test_output_backpressure();
      wait_for_results();
      gap_max         = 0;
      stall_pattern   = '1;
      rsp_hold_cycles = 100;
      random_ticks(40, 50, 50, 0);
      wait_for_results();
   endtask

   task automatic test_debounce_settings();
      configure(8'd1, 8'd1, 8'd1, samples_taken + 25'd15);
      pick_idling();
      random_ticks(60, 150, 300, 10);

      // longest debounce: hold the pins long enough to pass it and wrap
      configure(8'd255, 8'd255, 8'd255, RST_SAMPLE_LIMIT);
      pick_idling();
      held_pin[SW_BOAT]    = 1'b0;
      held_pin[SW_MOTOR]   = 1'b0;
      held_pin[SW_DEADMAN] = 1'b1;
      random_ticks(320, 0, 2, 0);

      // zero debounce: flags follow the pins; limit zero stops the sums
      configure(8'd0, 8'd0, 8'd0, '0);
      pick_idling();
      random_ticks(60, 500, 500, 10);

      configure(RST_DEBOUNCE_TICKS, RST_DEBOUNCE_TICKS, RST_DEBOUNCE_TICKS,
                RST_SAMPLE_LIMIT);
      pick_idling();
      random_ticks(60, 60, 60, 10);
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < 5; p++) begin
         configure(CNT_W'($urandom_range(12, 1)), CNT_W'($urandom_range(12, 1)),
                   CNT_W'($urandom_range(12, 1)),
                   $urandom_range(1) ? RST_SAMPLE_LIMIT
                                     : samples_taken + SAMPLE_W'($urandom_range(60)));
         pick_idling();
         // mostly clean switch sessions, one phase in five is chatter
         if (p == 2)
            random_ticks(80, 500, 500, 20);
         else
            random_ticks(80, 40, 50, 10);
      end
   endtask

   task automatic test_error_halt();
      tick_type t;
      pick_idling();
      while (error_visits < ERROR_HALT_COUNT) begin
         t            = quiet_tick();
         t.error_code = ERRC_W'($urandom_range(255, 1));
         send_tick(t);
      end
      // halted is terminal: errors, boat and levels all change nothing
      random_ticks(30, 300, 300, 0);
      t            = quiet_tick();
      t.boat_n     = 1'b0;
      t.error_code = 8'hFF;
      repeat (3) send_tick(t);
   endtask

   // ------------------------------------------------------------- processes

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready = stall_pattern[stall_phase];
            stall_phase++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_status.size() == 0) begin
            $error("status item with none expected, mode %0d", rsp_ch.mode);
            mismatch_count++;
         end else begin
            want_status = expected_status.pop_front();
            check_field("mode", 32'(want_status.mode), 32'(rsp_ch.mode));
            check_field("boat_on", 32'(want_status.boat_on), 32'(rsp_ch.boat_on));
            check_field("motor_active", 32'(want_status.motor_active),
                        32'(rsp_ch.motor_active));
            check_field("dead_man_on", 32'(want_status.dead_man_on),
                        32'(rsp_ch.dead_man_on));
            check_field("mcc_on", 32'(want_status.mcc_on), 32'(rsp_ch.mcc_on));
            check_field("pumps_on", 32'(want_status.pumps_on), 32'(rsp_ch.pumps_on));
            check_field("error_total", 32'(want_status.error_total),
                        32'(rsp_ch.error_total));
            check_field("pwm_sum", want_status.pwm_sum, rsp_ch.pwm_sum);
            check_field("ramp_sum", want_status.ramp_sum, rsp_ch.ramp_sum);
            check_field("power_sum", want_status.power_sum, rsp_ch.power_sum);
            check_field("sample_count", 32'(want_status.sample_count),
                        32'(rsp_ch.sample_count));
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset                  = 1'b1;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      req_ch.valid           = 1'b0;
      req_ch.boat_switch_n   = 1'b1;
      req_ch.motor_switch_n  = 1'b1;
      req_ch.dead_man_n      = 1'b1;
      req_ch.mcc_switch_n    = 1'b1;
      req_ch.pump_switches_n = '1;
      req_ch.pwm_pot_level   = '0;
      req_ch.ramp_pot_level  = '0;
      req_ch.power_pot_level = '0;
      req_ch.error_code      = '0;
      mismatch_count         = 0;
      burst_left             = 0;
      gap_max                = 0;
      stall_pattern          = '1;
      stall_phase            = '0;
      rsp_hold_cycles        = 0;
      reset_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ticks();
      test_output_backpressure();
      test_debounce_settings();
      test_random_traffic();
      test_error_halt();

      wait_for_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
